FILE: rtl/svc_pkg.sv
// Shared types, constants and control structs for the signed varint codec.
// No dependencies; imported by every module of the block.
package svc_pkg;

  localparam int ValueW = 32;
  localparam int ByteW  = 8;
  localparam int PosW   = 6;
  localparam int DataW  = 7;

  localparam logic [PosW-1:0]  PosLimit   = 6'd32;
  localparam logic [PosW-1:0]  PosFirst   = 6'd6;
  localparam logic [PosW:0]    PosStep    = 7'd7;
  localparam logic [ByteW-1:0] FirstMask  = 8'h3F;
  localparam logic [ByteW-1:0] ContBit    = 8'h80;
  localparam logic [ByteW-1:0] SignBit    = 8'h40;
  localparam logic [ByteW-1:0] DataMask   = 8'h7F;
  localparam int               FirstShift = 6;
  localparam int               NextShift  = 7;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  typedef struct packed {
    logic signed [ValueW-1:0] encode_value;
    logic [ByteW-1:0]         in_byte;
    logic                     end_of_input;
  } svc_in_t;

  typedef struct packed {
    logic [ByteW-1:0]         out_byte;
    logic                     last_of_run;
    logic signed [ValueW-1:0] decoded_value;
  } svc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_LOAD,
    ST_ENC_EMIT,
    ST_DEC_ACC,
    ST_DEC_DONE
  } svc_state_e;

  typedef struct packed {
    logic in_take;
    logic enc_load;
    logic enc_emit;
    logic dec_acc;
    logic dec_done;
  } svc_ctl_t;

  typedef struct packed {
    logic enc_last;
    logic dec_end;
    logic out_free;
  } svc_sts_t;

endpackage

FILE: rtl/svc_unit.sv
// Datapath of the signed varint codec: shared negator, decode shifter,
// encode byte slicer and the output register. Depends on svc_pkg.
module svc_unit
  import svc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  svc_ctl_t ctl_i,
  input  svc_in_t  in_data_i,
  input  logic     out_stall_i,
  output svc_sts_t sts_o,
  output logic     out_valid_o,
  output svc_out_t out_data_o
);

  svc_in_t            in_q;
  logic [ValueW-1:0]  enc_mag_q, enc_mag_d;
  logic               enc_neg_q, enc_neg_d;
  logic               enc_first_q, enc_first_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               neg_flag_q, neg_flag_d;
  logic               expect_first_q, expect_first_d;
  logic               out_valid_q, out_valid_d;
  svc_out_t           out_q, out_d;

  logic [ValueW-1:0]  neg_src, neg_res;
  logic [ValueW-1:0]  enc_next;
  logic [ByteW-1:0]   enc_byte;
  logic               enc_cont;
  logic [ValueW-1:0]  dec_shifted;
  logic [PosW:0]      pos_sum;
  logic [ByteW-1:0]   dec_byte;
  logic               out_free;

  // shared negator
  assign neg_src = ctl_i.enc_load ? in_q.encode_value : acc_q;
  assign neg_res = '0 - neg_src;

  assign enc_next = enc_first_q ? (enc_mag_q >> FirstShift) : (enc_mag_q >> NextShift);
  assign enc_cont = (enc_next != '0);
  always_comb begin
    if (enc_first_q) begin
      enc_byte = (enc_mag_q[ByteW-1:0] & FirstMask) | (enc_neg_q ? SignBit : '0);
    end else begin
      enc_byte = enc_mag_q[ByteW-1:0] & DataMask;
    end
    if (enc_cont) begin
      enc_byte = enc_byte | ContBit;
    end
  end

  assign dec_byte    = in_q.in_byte;
  assign dec_shifted = {{(ValueW-DataW){1'b0}}, dec_byte[DataW-1:0]} << pos_q[PosW-2:0];
  assign pos_sum     = {1'b0, pos_q} + PosStep;

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.enc_last = !enc_cont;
  assign sts_o.dec_end  = ((dec_byte & ContBit) == '0) || in_q.end_of_input;
  assign sts_o.out_free = out_free;

  always_comb begin
    enc_mag_d   = enc_mag_q;
    enc_neg_d   = enc_neg_q;
    enc_first_d = enc_first_q;
    if (ctl_i.enc_load) begin
      enc_neg_d   = in_q.encode_value[ValueW-1];
      enc_mag_d   = enc_neg_d ? neg_res : in_q.encode_value;
      enc_first_d = 1'b1;
    end else if (ctl_i.enc_emit) begin
      enc_mag_d   = enc_next;
      enc_first_d = 1'b0;
    end
  end

  always_comb begin
    acc_d          = acc_q;
    pos_d          = pos_q;
    neg_flag_d     = neg_flag_q;
    expect_first_d = expect_first_q;
    if (ctl_i.dec_acc) begin
      if (expect_first_q) begin
        neg_flag_d     = (dec_byte & SignBit) != '0;
        acc_d          = {{(ValueW-ByteW){1'b0}}, dec_byte & FirstMask};
        pos_d          = PosFirst;
        expect_first_d = 1'b0;
      end else if (pos_q < PosLimit) begin
        acc_d = acc_q | dec_shifted;
        pos_d = (pos_sum > {1'b0, PosLimit}) ? PosLimit : pos_sum[PosW-1:0];
      end
    end else if (ctl_i.dec_done) begin
      acc_d          = '0;
      pos_d          = '0;
      neg_flag_d     = 1'b0;
      expect_first_d = 1'b1;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctl_i.enc_emit) begin
      out_d.out_byte      = enc_byte;
      out_d.last_of_run   = !enc_cont;
      out_d.decoded_value = '0;
      out_valid_d         = 1'b1;
    end else if (ctl_i.dec_done) begin
      out_d.out_byte      = '0;
      out_d.last_of_run   = 1'b0;
      out_d.decoded_value = neg_flag_q ? neg_res : acc_q;
      out_valid_d         = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_take) begin
      in_q <= in_data_i;
    end
    enc_mag_q <= enc_mag_d;
    enc_neg_q <= enc_neg_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_first_q    <= 1'b1;
      acc_q          <= '0;
      pos_q          <= '0;
      neg_flag_q     <= 1'b0;
      expect_first_q <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      enc_first_q    <= enc_first_d;
      acc_q          <= acc_d;
      pos_q          <= pos_d;
      neg_flag_q     <= neg_flag_d;
      expect_first_q <= expect_first_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLimit)
    else $error("bit position beyond limit");

  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_first_q |-> (pos_q == '0 && acc_q == '0 && !neg_flag_q))
    else $error("decode state not clear between values");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.enc_emit || ctl_i.dec_done) |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.enc_load, ctl_i.enc_emit, ctl_i.dec_acc, ctl_i.dec_done}))
    else $error("more than one datapath operation");
`endif

endmodule

FILE: rtl/svc_ctrl.sv
// Sequencer of the signed varint codec: steps the datapath through encode
// and decode operations. Depends on svc_pkg.
module svc_ctrl
  import svc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     direction_i,
  input  logic     in_valid_i,
  input  svc_sts_t sts_i,
  output logic     in_stall_o,
  output svc_ctl_t ctl_o
);

  svc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (direction_i == DirDecode) ? ST_DEC_ACC : ST_ENC_LOAD;
        end
      end
      ST_ENC_LOAD: state_d = ST_ENC_EMIT;
      ST_ENC_EMIT: begin
        if (sts_i.out_free && sts_i.enc_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEC_ACC:  state_d = sts_i.dec_end ? ST_DEC_DONE : ST_IDLE;
      ST_DEC_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctl_o.in_take = in_valid_i;
      end
      ST_ENC_LOAD: ctl_o.enc_load = 1'b1;
      ST_ENC_EMIT: ctl_o.enc_emit = sts_i.out_free;
      ST_DEC_ACC:  ctl_o.dec_acc  = 1'b1;
      ST_DEC_DONE: ctl_o.dec_done = sts_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/signed_varint_codec_core.sv
// Top level of the signed varint codec: direction register, sequencer and
// datapath. Depends on svc_pkg, svc_ctrl and svc_unit.
//
// Sign-magnitude varint encoder/decoder. With the direction register at 0
// each input transaction carries a signed 32-bit value and yields 1 to 5
// output bytes, least significant group first, the final one flagged by
// last_of_run; with it at 1 each input transaction carries one byte and a
// value is emitted when a byte has bit 7 clear or end_of_input set. One input
// is handled at a time: an encode is loaded, then emits its bytes in turn;
// a decode byte is accumulated, then, when it completes a value, the value is
// emitted. Both directions share the single negator of the datapath
// (two's complement on the way in for encode, on the way out for decode).
// Output stalls hold the sequencer. Write the direction only while idle.
module signed_varint_codec_core
  import svc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  svc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output svc_out_t out_data_o
);

  logic     direction_q;
  svc_ctl_t ctl;
  svc_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DirEncode;
    end else if (cfg_we_i) begin
      direction_q <= cfg_wdata_i;
    end
  end

  svc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction_q),
    .in_valid_i  (in_valid_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .ctl_o       (ctl)
  );

  svc_unit u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
